// ===== hw/rtl/bf5_pkg.sv =====
// bf5_pkg: shared constants, register codes and the queue entry type
// for the 5x5 box filter. No dependencies.
`default_nettype none

package bf5_pkg;

    // Geometry and field widths
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int PIX_W         = 8;
    localparam int IW_W          = 12;
    localparam int IH_W          = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 1;

    // Register reset values
    localparam logic [IW_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [IH_W-1:0] HEIGHT_RST = 16'd480;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Window and line buffer
    localparam int WIN_DIM  = 5;
    localparam int LB_TAPS  = WIN_DIM - 1;
    localparam int LB_W     = LB_TAPS * PIX_W;
    localparam int TAP_W    = 3;

    // Sums and the divide by 25: floor(x / 25) == (x * 5243) >> 17 for x < 43690
    localparam int VSUM_W      = 11;
    localparam int HSUM_W      = 13;
    localparam int RECIP_W     = 13;
    localparam int PROD_W      = HSUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = 13'd5243;
    localparam int RECIP_SHIFT = 17;

    // Front to back queue
    localparam int Q_DEPTH = 4;

    // Per-transaction control worked out by the front end
    typedef struct packed {
        logic [PIX_W-1:0] sample;  // pixel to push into the line buffer
        logic [TAP_W-1:0] vtop;    // highest usable row tap (rows available above)
        logic [TAP_W-1:0] vbot;    // lowest usable row tap (rows past the bottom edge)
        logic [TAP_W-1:0] htop;    // highest usable column age
        logic [1:0]       hlo;     // lowest usable column age
        logic             emit;    // this transaction produces a result
        logic             last;    // result is the final one of the frame
    } item_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/box_filter_5x5_top.sv =====
// box_filter_5x5_top: top level of the streaming 5x5 box filter.
// Instantiates bf5_front, bf5_queue and bf5_back; uses bf5_pkg.
`default_nettype none

// Streaming 5x5 mean filter for 8-bit grayscale frames with replicated
// borders. Send the W*H pixels of a frame in raster order (opcode pixel),
// then exactly 2W+2 drain transactions (opcode drain); the result for raster
// position k leaves with input transaction k+2W+2, and the final result of a
// frame carries last_of_frame. The transaction after the last drain starts the
// next frame. Each result is floor(sum of the 25 neighbours / 25). Rate: one
// transaction per clock sustained while results are taken, limited by the
// single write and single read port of the line-buffer RAM (one 32-bit word
// per column holding the four previous rows). An emitting transaction passes
// the queue, the s1, s2 and s3 stages and the result register. The front end
// takes transactions into a four-entry queue, so s_ready depends only on
// queue space; the back end pipeline advances whenever its result register
// is empty or being taken. Writing image_width or image_height restarts the
// frame counters; write only while idle. Width 0 and height 0 act as 1,
// widths above MAX_WIDTH saturate. The line buffer needs no clearing after
// reset: only rows of the current frame are ever selected.
module box_filter_5x5_top #(
    parameter int MAX_WIDTH = bf5_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write port
    input  wire logic                          cfg_wr_en,
    input  wire logic [bf5_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bf5_pkg::CFG_W-1:0]     cfg_wdata,
    // input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_opcode,
    input  wire logic [bf5_pkg::PIX_W-1:0]     s_pixel,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [bf5_pkg::PIX_W-1:0]     m_smoothed,
    output logic                               m_last_of_frame
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CTL_W  = $bits(bf5_pkg::item_ctl_t);
    localparam int ENTRY_W = CTL_W + COL_W;

    logic                   q_full;
    logic                   q_empty;
    logic                   push;
    logic                   pop;
    bf5_pkg::item_ctl_t     push_ctl;
    logic [COL_W-1:0]       push_col;
    logic [ENTRY_W-1:0]     head_data;
    bf5_pkg::item_ctl_t     head_ctl;
    logic [COL_W-1:0]       head_col;

    // Front end: config registers, handshake, raster position and clamp limits
    bf5_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_opcode  (s_opcode),
        .s_pixel   (s_pixel),
        .q_full    (q_full),
        .push      (push),
        .push_ctl  (push_ctl),
        .push_col  (push_col)
    );

    // Decoupling queue: each entry is the control struct plus the column
    bf5_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (bf5_pkg::Q_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_ctl, push_col}),
        .pop       (pop),
        .pop_data  (head_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign head_ctl = bf5_pkg::item_ctl_t'(head_data[ENTRY_W-1:COL_W]);
    assign head_col = head_data[COL_W-1:0];

    // Back end: line buffer, window sums, divide, result register
    bf5_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .head_ctl        (head_ctl),
        .head_col        (head_col),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_smoothed      (m_smoothed),
        .m_last_of_frame (m_last_of_frame)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/bf5_ram.sv =====
// bf5_ram: generic simple dual-port RAM, one write and one read port,
// registered read-first output. No dependencies beyond bf5_pkg defaults.
`default_nettype none

module bf5_ram #(
    parameter int WIDTH = bf5_pkg::LB_W,
    parameter int DEPTH = bf5_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bf5_front.sv =====
// bf5_front: configuration registers, input handshake and raster
// bookkeeping; classifies each transaction for the back end. Uses bf5_pkg.
`default_nettype none

module bf5_front #(
    parameter int MAX_WIDTH = bf5_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [bf5_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bf5_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_opcode,
    input  wire logic [bf5_pkg::PIX_W-1:0]        s_pixel,
    input  wire logic                             q_full,
    output logic                                  push,
    output bf5_pkg::item_ctl_t                    push_ctl,
    output logic      [$clog2(MAX_WIDTH)-1:0]     push_col
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WEFF_W = COL_W + 1;
    localparam int CMP_W  = (bf5_pkg::IW_W > WEFF_W) ? bf5_pkg::IW_W : WEFF_W;
    localparam int LAT_W  = COL_W + 2;
    localparam int ROW_W  = bf5_pkg::IH_W + 1;
    localparam int SUM_W  = WEFF_W + 1;

    logic [bf5_pkg::IW_W-1:0] image_width_reg;
    logic [bf5_pkg::IH_W-1:0] image_height_reg;

    logic [COL_W-1:0]         in_col_reg,   in_col_next;
    logic [ROW_W-1:0]         in_row_reg,   in_row_next;
    logic [COL_W-1:0]         out_col_reg,  out_col_next;
    logic [bf5_pkg::IH_W-1:0] out_row_reg,  out_row_next;
    logic [LAT_W-1:0]         lead_cnt_reg, lead_cnt_next;

    logic [CMP_W-1:0]         wz;
    logic [WEFF_W-1:0]        weff;
    logic [bf5_pkg::IH_W-1:0] heff;
    logic [LAT_W-1:0]         lat;
    logic                     emit;
    logic                     in_wlast;
    logic                     out_wlast;
    logic                     out_hlast;
    logic                     last;
    logic [ROW_W-1:0]         row_p1;
    logic [SUM_W-1:0]         col_p3;

    // Effective geometry: zero reads as one, width saturates at MAX_WIDTH
    assign wz   = (image_width_reg == '0) ? CMP_W'(1) : CMP_W'(image_width_reg);
    assign weff = (wz > CMP_W'(MAX_WIDTH)) ? WEFF_W'(MAX_WIDTH) : WEFF_W'(wz);
    assign heff = (image_height_reg == '0) ? bf5_pkg::IH_W'(1) : image_height_reg;
    assign lat  = LAT_W'({weff, 1'b0}) + LAT_W'(2);

    assign emit      = (lead_cnt_reg == lat);
    assign in_wlast  = (WEFF_W'(in_col_reg) == weff - WEFF_W'(1));
    assign out_wlast = (WEFF_W'(out_col_reg) == weff - WEFF_W'(1));
    assign out_hlast = (out_row_reg == heff - bf5_pkg::IH_W'(1));
    assign last      = emit && out_wlast && out_hlast;

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    assign row_p1 = in_row_reg + ROW_W'(1);
    assign col_p3 = SUM_W'(out_col_reg) + SUM_W'(3);

    // Clamp limits: row taps count back in whole rows from the incoming one,
    // column ages count back in transactions from the incoming one.
    always_comb begin
        push_ctl.sample = (s_opcode == bf5_pkg::OP_DRAIN) ? '0 : s_pixel;
        push_ctl.vtop   = (in_row_reg >= ROW_W'(4)) ? 3'd4 : in_row_reg[2:0];
        push_ctl.vbot   = (row_p1 > ROW_W'(heff)) ? 3'(row_p1 - ROW_W'(heff)) : 3'd0;
        push_ctl.htop   = (out_col_reg >= COL_W'(2)) ? 3'd4 : 3'(out_col_reg) + 3'd2;
        push_ctl.hlo    = (col_p3 > SUM_W'(weff)) ? 2'(col_p3 - SUM_W'(weff)) : 2'd0;
        push_ctl.emit   = emit;
        push_ctl.last   = last;
    end

    assign push_col = in_col_reg;

    always_comb begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        lead_cnt_next = lead_cnt_reg;
        if (cfg_wr_en || (push && last)) begin
            in_col_next   = '0;
            in_row_next   = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            lead_cnt_next = '0;
        end else if (push) begin
            if (in_wlast) begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end else begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (!emit) begin
                lead_cnt_next = lead_cnt_reg + LAT_W'(1);
            end else if (out_wlast) begin
                out_col_next = '0;
                out_row_next = out_row_reg + bf5_pkg::IH_W'(1);
            end else begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= bf5_pkg::WIDTH_RST;
            image_height_reg <= bf5_pkg::HEIGHT_RST;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            lead_cnt_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (bf5_pkg::cfg_reg_t'(cfg_index))
                    bf5_pkg::REG_IMAGE_WIDTH: begin
                        image_width_reg <= cfg_wdata[bf5_pkg::IW_W-1:0];
                    end
                    bf5_pkg::REG_IMAGE_HEIGHT: begin
                        image_height_reg <= cfg_wdata[bf5_pkg::IH_W-1:0];
                    end
                endcase
            end
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            lead_cnt_reg <= lead_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bf5_queue.sv =====
// bf5_queue: small register FIFO between the front and back ends.
// Uses bf5_pkg for the default depth.
`default_nettype none

module bf5_queue #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = bf5_pkg::Q_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic              pop,
    output logic      [DATA_W-1:0] pop_data,
    output logic                   full,
    output logic                   empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [DATA_W-1:0] buf_reg [0:DEPTH-1];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = buf_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bf5_back.sv =====
// bf5_back: line buffer, 5x5 window sums, divide by 25 and result register.
// Uses bf5_pkg and bf5_ram.
`default_nettype none

module bf5_back #(
    parameter int MAX_WIDTH = bf5_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         q_empty,
    input  wire bf5_pkg::item_ctl_t           head_ctl,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] head_col,
    output logic                              pop,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [bf5_pkg::PIX_W-1:0]    m_smoothed,
    output logic                              m_last_of_frame
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int PIX_W = bf5_pkg::PIX_W;
    localparam int LB_W  = bf5_pkg::LB_W;
    localparam int WIN   = bf5_pkg::WIN_DIM;
    localparam int TAP_W = bf5_pkg::TAP_W;

    function automatic logic [TAP_W-1:0] clamp_tap(
        input logic [TAP_W-1:0] d,
        input logic [TAP_W-1:0] lo,
        input logic [TAP_W-1:0] hi
    );
        logic [TAP_W-1:0] r;
        r = d;
        if (d > hi) begin
            r = hi;
        end else if (d < lo) begin
            r = lo;
        end
        return r;
    endfunction

    logic                        bk_en;

    // Stage 1: line buffer read data available
    logic                        s1_valid_reg;
    bf5_pkg::item_ctl_t          s1_ctl_reg;
    logic [COL_W-1:0]            s1_col_reg;
    logic                        s1_fwd_reg;
    logic [LB_W-1:0]             fwd_data_reg;
    logic [LB_W-1:0]             ram_rd_data;
    logic [LB_W-1:0]             prev_rows;
    logic [LB_W-1:0]             lb_wdata;
    logic [PIX_W-1:0]            taps [0:WIN-1];
    logic [bf5_pkg::VSUM_W-1:0]  vsum;

    // Stage 2: column sums history
    logic                        s2_valid_reg;
    bf5_pkg::item_ctl_t          s2_ctl_reg;
    logic [bf5_pkg::VSUM_W-1:0]  hist_reg [0:WIN-1];
    logic [bf5_pkg::HSUM_W-1:0]  hsum;

    // Stage 3: divide
    logic                        s3_valid_reg;
    logic [bf5_pkg::HSUM_W-1:0]  s3_sum_reg;
    logic                        s3_last_reg;
    logic [bf5_pkg::PROD_W-1:0]  prod;

    // Result register
    logic                        out_valid_reg;
    logic [PIX_W-1:0]            out_smoothed_reg;
    logic                        out_last_reg;

    assign bk_en = !out_valid_reg || m_ready;
    assign pop   = bk_en && !q_empty;

    bf5_ram #(
        .WIDTH (LB_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (bk_en && s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (lb_wdata),
        .rd_en   (pop),
        .rd_addr (head_col),
        .rd_data (ram_rd_data)
    );

    // Width of one: the same column is read and written in the same cycle
    assign prev_rows = s1_fwd_reg ? fwd_data_reg : ram_rd_data;
    assign lb_wdata  = {prev_rows[LB_W-PIX_W-1:0], s1_ctl_reg.sample};

    always_comb begin
        taps[0] = s1_ctl_reg.sample;
        for (int i = 1; i < WIN; i++) begin
            taps[i] = prev_rows[(i-1)*PIX_W +: PIX_W];
        end
        vsum = '0;
        for (int d = 0; d < WIN; d++) begin
            vsum = vsum + bf5_pkg::VSUM_W'(
                taps[clamp_tap(TAP_W'(d), s1_ctl_reg.vbot, s1_ctl_reg.vtop)]);
        end
    end

    always_comb begin
        hsum = '0;
        for (int d = 0; d < WIN; d++) begin
            hsum = hsum + bf5_pkg::HSUM_W'(
                hist_reg[clamp_tap(TAP_W'(d), TAP_W'(s2_ctl_reg.hlo), s2_ctl_reg.htop)]);
        end
    end

    assign prod = bf5_pkg::PROD_W'(s3_sum_reg) * bf5_pkg::PROD_W'(bf5_pkg::RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (bk_en) begin
            s1_valid_reg  <= !q_empty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg && s2_ctl_reg.emit;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (bk_en) begin
            s1_ctl_reg   <= head_ctl;
            s1_col_reg   <= head_col;
            s1_fwd_reg   <= s1_valid_reg && (s1_col_reg == head_col);
            fwd_data_reg <= lb_wdata;
            if (s1_valid_reg) begin
                hist_reg[0] <= vsum;
                for (int i = 1; i < WIN; i++) begin
                    hist_reg[i] <= hist_reg[i-1];
                end
            end
            s2_ctl_reg       <= s1_ctl_reg;
            s3_sum_reg       <= hsum;
            s3_last_reg      <= s2_ctl_reg.last;
            out_smoothed_reg <= prod[bf5_pkg::RECIP_SHIFT +: PIX_W];
            out_last_reg     <= s3_last_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_smoothed      = out_smoothed_reg;
    assign m_last_of_frame = out_last_reg;

endmodule

`default_nettype wire

// ===== sim/tb_box_filter_5x5_top.sv =====
// tb_box_filter_5x5_top: self-checking testbench for the streaming 5x5 box filter.
// Needs bf5_pkg and box_filter_5x5_top; predicts every result and checks it in order.
`timescale 1ns / 1ps

module tb_box_filter_5x5_top;

    import bf5_pkg::*;

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on either side
    localparam int RANDOM_ITEMS   = 450;

    localparam int STORE_DEPTH = 5 * MAX_WIDTH_DEF;  // raster index p kept at p mod depth
    localparam int WIN_RADIUS  = 2;
    localparam int WIN_AREA    = 25;

    // pixel value styles for generated frames
    localparam int PIX_RANDOM  = 0;
    localparam int PIX_EXTREME = 1;
    localparam int PIX_BRIGHT  = 2;

    // receiver stall modes
    localparam int RX_FREE     = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;

    typedef struct packed {
        logic [PIX_W-1:0] smoothed;
        logic             last_of_frame;
    } box_result_t;

    // ------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------
    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    logic             s_opcode  = OP_PIXEL;
    logic [PIX_W-1:0] s_pixel   = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    logic [PIX_W-1:0] m_smoothed;
    logic             m_last_of_frame;

    box_filter_5x5_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_pixel         (s_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_smoothed      (m_smoothed),
        .m_last_of_frame (m_last_of_frame)
    );

    // 2 ns period
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Filter predictor state: its own copy of the registers, the pixel
    // store and the frame counters.
    // ------------------------------------------------------------------
    logic [IW_W-1:0]  cfg_width;
    logic [IH_W-1:0]  cfg_height;
    logic [PIX_W-1:0] line_store [STORE_DEPTH];
    int unsigned      frame_pos;   // transactions taken in the current frame
    int               res_row;     // raster position of the next result
    int               res_col;
    box_result_t      expected_q [$];
    int               error_count = 0;

    // stimulus bookkeeping
    int unsigned sent_count = 0;
    int unsigned burst_left = 0;
    bit          need_cfg   = 1'b0;

    // Width 0 acts as 1, widths above the line buffer saturate
    function automatic int unsigned frame_width();
        if (cfg_width == '0)
            return 1;
        if (cfg_width > MAX_WIDTH_DEF)
            return MAX_WIDTH_DEF;
        return cfg_width;
    endfunction

    function automatic int unsigned frame_height();
        return (cfg_height == '0) ? 1 : cfg_height;
    endfunction

    // W*H pixels followed by 2W+2 drain transactions
    function automatic int unsigned frame_length();
        return frame_width() * frame_height() + 2 * frame_width() + 2;
    endfunction

    function automatic int clamp_index(input int v, input int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // One accepted input transaction: store its sample while in the pixel
    // phase, and emit the mean for the position 2W+2 behind it, if any.
    function automatic void smooth_transaction(input logic op, input logic [PIX_W-1:0] pix);
        int unsigned w, h, npix, lead, sum;
        int          rr, cc, dy, dx;
        box_result_t res;
        w    = frame_width();
        h    = frame_height();
        npix = w * h;
        lead = 2 * w + 2;
        // a drain in the pixel phase still takes its raster slot, as a zero
        if (frame_pos < npix)
            line_store[frame_pos % STORE_DEPTH] = (op == OP_DRAIN) ? '0 : pix;
        if (frame_pos >= lead && frame_pos - lead < npix) begin
            sum = 0;
            for (dy = -WIN_RADIUS; dy <= WIN_RADIUS; dy++) begin
                rr = clamp_index(res_row + dy, int'(h) - 1);
                for (dx = -WIN_RADIUS; dx <= WIN_RADIUS; dx++) begin
                    cc = clamp_index(res_col + dx, int'(w) - 1);
                    sum += line_store[(rr * w + cc) % STORE_DEPTH];
                end
            end
            res.smoothed      = PIX_W'(sum / WIN_AREA);
            res.last_of_frame = (frame_pos - lead == npix - 1);
            expected_q.push_back(res);
            res_col++;
            if (res_col >= int'(w)) begin
                res_col = 0;
                res_row++;
            end
        end
        if (frame_pos >= npix + lead - 1) begin
            frame_pos = 0;
            res_row   = 0;
            res_col   = 0;
        end else begin
            frame_pos++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor and scoreboard: everything is sampled at the rising edge,
    // where the testbench-driven inputs, set on the falling edge, are stable.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : scoreboard
        box_result_t want;
        if (!aresetn) begin
            cfg_width  = WIDTH_RST;
            cfg_height = HEIGHT_RST;
            frame_pos  = 0;
            res_row    = 0;
            res_col    = 0;
        end else begin
            // any register write restarts the frame; the store is kept
            if (cfg_wr_en) begin
                if (cfg_reg_t'(cfg_index) == REG_IMAGE_WIDTH)
                    cfg_width = cfg_wdata[IW_W-1:0];
                else
                    cfg_height = cfg_wdata[IH_W-1:0];
                frame_pos = 0;
                res_row   = 0;
                res_col   = 0;
            end
            if (s_valid && s_ready)
                smooth_transaction(s_opcode, s_pixel);
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result: smoothed %0d last_of_frame %0b",
                           m_smoothed, m_last_of_frame);
                    error_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_smoothed !== want.smoothed) begin
                        $error("smoothed: expected %0d, got %0d", want.smoothed, m_smoothed);
                        error_count++;
                    end
                    if (m_last_of_frame !== want.last_of_frame) begin
                        $error("last_of_frame: expected %0b, got %0b",
                               want.last_of_frame, m_last_of_frame);
                        error_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: changes m_ready on the falling edge. It switches between
    // free running, random stalls and a fixed duty pattern after stretches
    // of random length, so stalls land on every phase of the pipeline.
    // ------------------------------------------------------------------
    int unsigned rx_mode = RX_FREE;
    int unsigned rx_left = 0;
    int unsigned rx_tick = 0;

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(RX_FREE, RX_PERIODIC);
            rx_left = $urandom_range(50, 400);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_FREE:   m_ready <= 1'b1;
            RX_RANDOM: m_ready <= ($urandom_range(0, 99) >= 35);
            default:   m_ready <= ((rx_tick % 7) < 4);
        endcase
    end

    // ------------------------------------------------------------------
    // Watchdog: a hang is any long stretch with no transaction accepted
    // on either channel. Reset and the settle pauses stay far below it.
    // ------------------------------------------------------------------
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. All run from the falling edge.
    // ------------------------------------------------------------------

    // Send one transaction. The sender runs in bursts of random length;
    // between bursts it may drop valid for a random gap, often zero, so
    // long gap-free stretches occur too.
    task automatic send_item(input logic op, input logic [PIX_W-1:0] pix);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 48);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_pixel  <= pix;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
        @(negedge aclk);
    endtask

    // Drop valid, wait for every expected result, then give the pipeline
    // time to finish transactions that produce nothing.
    task automatic wait_quiet();
        s_valid   <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write both registers on consecutive cycles while the block is idle
    task automatic configure(input logic [CFG_W-1:0] width_val,
                             input logic [CFG_W-1:0] height_val);
        wait_quiet();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_wdata <= width_val;
        @(negedge aclk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_wdata <= height_val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        need_cfg = 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(input int unsigned style);
        case (style)
            PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            PIX_BRIGHT:  return PIX_W'($urandom_range(230, 255));
            default:     return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Send a frame for the current geometry, cut short after max_items.
    // noise_pct flips the opcode of that share of the transactions.
    task automatic send_frame(input int unsigned noise_pct, input int unsigned style,
                              input int unsigned max_items);
        int unsigned npix, total, i;
        npix  = frame_width() * frame_height();
        total = frame_length();
        if (max_items < total)
            total = max_items;
        for (i = 0; i < total; i++) begin
            if (i < npix)
                send_item(($urandom_range(0, 99) < noise_pct) ? OP_DRAIN : OP_PIXEL,
                          pick_pixel(style));
            else
                send_item(($urandom_range(0, 99) < noise_pct) ? OP_PIXEL : OP_DRAIN,
                          pick_pixel(style));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset geometry is 640x480: a handful of pixels must give no result
    task automatic test_reset_defaults();
        repeat (6) send_item(OP_PIXEL, pick_pixel(PIX_RANDOM));
    endtask

    // Smallest frames, where drains outnumber pixels and some drains
    // produce nothing. Zero width and height act as 1; register bits above
    // the width field are ignored.
    task automatic test_tiny_frames();
        configure(16'h0000, 16'h0000);
        send_item(OP_PIXEL, 8'hFF);
        repeat (4) send_item(OP_DRAIN, 8'h5A);
        // second 1x1 frame right behind, no register write
        send_item(OP_PIXEL, 8'h00);
        repeat (4) send_item(OP_DRAIN, 8'hFF);
        configure(16'h1002, 16'h0001);
        send_item(OP_PIXEL, 8'hFF);
        send_item(OP_PIXEL, 8'hFE);
        repeat (6) send_item(OP_DRAIN, 8'h81);
    endtask

    // Wrong opcodes: a drain in the pixel phase stores a zero sample, a
    // pixel in the drain phase is just another drain.
    task automatic test_opcode_mix();
        configure(16'd3, 16'd2);
        send_item(OP_PIXEL, 8'd10);
        send_item(OP_DRAIN, 8'hAA);
        send_item(OP_PIXEL, 8'd200);
        send_item(OP_PIXEL, 8'd255);
        send_item(OP_DRAIN, 8'h77);
        send_item(OP_PIXEL, 8'd1);
        repeat (4) begin
            send_item(OP_PIXEL, 8'hC3);
            send_item(OP_DRAIN, 8'h3C);
        end
    endtask

    // All width bits set: saturates to the line buffer width. The frame is
    // cut short well before its first result, so none may appear.
    task automatic test_wide_rows();
        configure(16'h0FFF, 16'd2);
        send_frame(0, PIX_RANDOM, 200);
        need_cfg = 1'b1;
    endtask

    // Tallest frame, one column wide; the frame is abandoned partway and
    // the next register write restarts the counters.
    task automatic test_tall_column();
        configure(16'd1, 16'hFFFF);
        send_frame(0, PIX_EXTREME, 150);
        need_cfg = 1'b1;
    endtask

    // Frames back to back: the transaction after the last drain opens the
    // next frame without any register write.
    task automatic test_back_to_back();
        configure(16'd5, 16'd4);
        send_frame(0, PIX_RANDOM, frame_length());
        send_frame(0, PIX_BRIGHT, frame_length());
        send_frame(0, PIX_EXTREME, frame_length());
    endtask

    // Mostly well-formed frames of random small geometry, some with
    // flipped opcodes, some cut short and followed by a new setting.
    task automatic test_random_frames();
        int unsigned start, kind, style, w, h, pick;
        start = sent_count;
        while (sent_count - start < RANDOM_ITEMS) begin
            if (need_cfg || $urandom_range(0, 99) < 60) begin
                pick = $urandom_range(0, 99);
                w = (pick < 8) ? 0 : (pick < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
                pick = $urandom_range(0, 99);
                h = (pick < 8) ? 0 : (pick < 90) ? $urandom_range(1, 8) : $urandom_range(9, 12);
                // random junk above the width field
                configure({4'($urandom_range(0, 15)), IW_W'(w)}, CFG_W'(h));
            end
            kind  = $urandom_range(0, 99);
            style = $urandom_range(PIX_RANDOM, PIX_BRIGHT);
            if (kind < 70) begin
                send_frame(0, style, frame_length());
            end else if (kind < 85) begin
                send_frame($urandom_range(5, 50), style, frame_length());
            end else begin
                send_frame(0, style, $urandom_range(1, frame_length() - 1));
                need_cfg = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_tiny_frames();
        test_opcode_mix();
        test_wide_rows();
        test_tall_column();
        test_back_to_back();
        test_random_frames();

        wait_quiet();
        if (error_count == 0 && expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bf5_pkg.sv
hw/rtl/bf5_ram.sv
hw/rtl/bf5_front.sv
hw/rtl/bf5_queue.sv
hw/rtl/bf5_back.sv
hw/rtl/box_filter_5x5_top.sv
sim/tb_box_filter_5x5_top.sv
